// ----- rtl/bpc_pkg.sv -----
// Package for the barometer pressure compensation block.
// Holds payload structs, config indexes, sequencer states and shared constants.
package bpc_pkg;

    typedef struct packed {
        logic              action;
        logic signed [23:0] raw_sample;
    } bpc_in_t;

    typedef struct packed {
        logic               kind;
        logic               status;
        logic signed [31:0] scaled_raw;
        logic signed [63:0] compensated;
    } bpc_out_t;

    typedef enum logic [2:0] {
        CFG_CALIB0    = 3'd0,
        CFG_CALIB1    = 3'd1,
        CFG_CALIB2    = 3'd2,
        CFG_MODE      = 3'd3,
        CFG_PRS_SCALE = 3'd4,
        CFG_TMP_SCALE = 3'd5
    } bpc_cfg_idx_t;

    localparam logic [2:0] MODE_PRS      = 3'd1;
    localparam logic [2:0] MODE_TMP      = 3'd2;
    localparam logic [2:0] MODE_CONT_PRS = 3'd5;
    localparam logic [2:0] MODE_CONT_TMP = 3'd6;
    localparam logic [2:0] MODE_BOTH     = 3'd7;

    localparam logic [20:0] SCALE_RESET = 21'd524288;
    localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCALE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_FIN,
        ST_ADD,
        ST_OUT
    } bpc_state_t;

    // Saturating signed 64-bit add
    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        begin
            s = a + b;
            if (!a[63] && !b[63] && s[63])
                sat_add64 = S64_MAX;
            else if (a[63] && b[63] && !s[63])
                sat_add64 = S64_MIN;
            else
                sat_add64 = s;
        end
    endfunction

endpackage

// ----- rtl/bpc_mulq.sv -----
// Serial Q47.16 x Q5.26 multiplier: magnitude times magnitude in two 32x32
// partial products, truncated toward zero and saturated.  Uses bpc_pkg.
module bpc_mulq (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] x,
    input  logic [31:0] y,
    output logic        done,
    output logic [63:0] prod
);
    import bpc_pkg::*;

    logic [1:0]  phase_reg, phase_next;
    logic [63:0] mx_reg, mx_next;
    logic [31:0] my_reg, my_next;
    logic        neg_reg, neg_next;
    logic [63:0] lp_reg, lp_next;
    logic [63:0] hp_reg, hp_next;
    logic [63:0] prod_reg, prod_next;
    logic        done_reg, done_next;

    logic [31:0] op_a;
    logic [63:0] mul_out;
    logic [63:0] lim;
    logic [63:0] r;

    // shared 32x32 multiplier
    assign op_a    = (phase_reg == 2'd1) ? mx_reg[31:0] : mx_reg[63:32];
    assign mul_out = {32'd0, op_a} * {32'd0, my_reg};
    assign lim     = neg_reg ? S64_MIN : S64_MAX;

    always_comb
    begin
        r = (hp_reg << 6) + {26'd0, lp_reg[63:26]};
        if (hp_reg > {6'd0, lim[63:6]})
            r = lim;
        else if (r > lim)
            r = lim;
    end

    always_comb
    begin
        phase_next = phase_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        neg_next   = neg_reg;
        lp_next    = lp_reg;
        hp_next    = hp_reg;
        prod_next  = prod_reg;
        done_next  = 1'b0;
        case (phase_reg)
            2'd0:
            begin
                if (start)
                begin
                    neg_next   = x[63] ^ y[31];
                    mx_next    = x[63] ? (64'd0 - x) : x;
                    my_next    = y[31] ? (32'd0 - y) : y;
                    phase_next = 2'd1;
                end
            end
            2'd1:
            begin
                lp_next    = mul_out;
                phase_next = 2'd2;
            end
            2'd2:
            begin
                hp_next    = mul_out;
                phase_next = 2'd3;
            end
            default:
            begin
                prod_next  = neg_reg ? (64'd0 - r) : r;
                done_next  = 1'b1;
                phase_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        neg_reg  <= neg_next;
        lp_reg   <= lp_next;
        hp_reg   <= hp_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ----- rtl/bpc_div.sv -----
// Restoring divider for the raw-sample scaling: (|raw| << 26) / scale,
// one quotient bit per cycle over 50 dividend bits.  Uses bpc_pkg.
module bpc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [49:0] dividend,
    input  logic [20:0] divisor,
    output logic        done,
    output logic [49:0] quotient
);
    import bpc_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [49:0] q_reg, q_next;
    logic [21:0] rem_reg, rem_next;
    logic [20:0] d_reg, d_next;
    logic        done_reg, done_next;
    logic [21:0] trial;

    assign trial = {rem_reg[20:0], q_reg[49]};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                cnt_next  = 6'd0;
                q_next    = dividend;
                rem_next  = 22'd0;
                d_next    = (divisor == 21'd0) ? 21'd1 : divisor;
            end
        end
        else
        begin
            // one shift-subtract step
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = trial - {1'b0, d_reg};
                q_next   = {q_reg[48:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[48:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd49)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- rtl/barometer_pressure_compensation.sv -----
// Barometer pressure and temperature compensation. Each item scales the raw
// sample by a 50-step serial divider, then runs the compensation polynomial
// through one shared two-pass 32x32 multiplier and a saturating adder under a
// small op sequencer. A temperature item runs one serial product and a
// pressure item seven; an item whose kind the mode forbids goes straight to
// the output stage without a divide or a product.
// Ready is low while an item is in progress.
// Depends on bpc_pkg, bpc_div and bpc_mulq.
module barometer_pressure_compensation #(
    parameter int RAW_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bpc_pkg::bpc_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bpc_pkg::bpc_out_t  out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data
);
    import bpc_pkg::*;

    // config registers
    logic [47:0] cal0_reg, cal1_reg, cal2_reg;
    logic [2:0]  mode_reg;
    logic [20:0] pscale_reg, tscale_reg;
    logic signed [31:0] tlast_reg, tlast_next;

    bpc_state_t state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic       kind_reg, kind_next;
    logic       status_reg, status_next;
    logic [31:0] sc_reg, sc_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] g_reg, g_next;
    logic [63:0] mres_reg, mres_next;
    logic signed [RAW_BITS-1:0] raw_reg, raw_next;
    logic        neg_reg, neg_next;
    bpc_out_t    out_reg, out_next;
    logic        ovalid_reg, ovalid_next;

    logic        div_start, div_done;
    logic [49:0] div_q;
    logic [49:0] div_dvd;
    logic        mul_start, mul_done;
    logic [63:0] mul_x, mul_prod;
    logic [31:0] mul_y;
    logic [63:0] add_a, add_b;

    logic [7:0] cb [18];
    logic signed [63:0] c0q, c1q, c00q, c10q, c01q, c11q, c20q, c21q, c30q;
    logic [RAW_BITS-1:0] mag;
    logic [31:0] scaled;
    logic        allowed;

    // calibration byte unpack
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            cb[i]      = cal0_reg[47 - 8*i -: 8];
            cb[i + 6]  = cal1_reg[47 - 8*i -: 8];
            cb[i + 12] = cal2_reg[47 - 8*i -: 8];
        end
    end

    always_comb
    begin
        c0q  = 64'(signed'({cb[0], cb[1][7:4]})) <<< 15;
        c1q  = 64'(signed'({cb[1][3:0], cb[2]})) <<< 16;
        c00q = 64'(signed'({cb[3], cb[4], cb[5][7:4]})) <<< 16;
        c10q = 64'(signed'({cb[5][3:0], cb[6], cb[7]})) <<< 16;
        c01q = 64'(signed'({cb[8], cb[9]})) <<< 16;
        c11q = 64'(signed'({cb[10], cb[11]})) <<< 16;
        c20q = 64'(signed'({cb[12], cb[13]})) <<< 16;
        c21q = 64'(signed'({cb[14], cb[15]})) <<< 16;
        c30q = 64'(signed'({cb[16], cb[17]})) <<< 16;
    end

    always_comb
    begin
        if (in_data.action)
            allowed = (mode_reg == MODE_PRS) || (mode_reg == MODE_CONT_PRS)
                   || (mode_reg == MODE_BOTH);
        else
            allowed = (mode_reg == MODE_TMP) || (mode_reg == MODE_CONT_TMP)
                   || (mode_reg == MODE_BOTH);
    end

    assign mag     = raw_reg[RAW_BITS-1] ? (RAW_BITS'(0) - raw_reg) : raw_reg;
    assign div_dvd = 50'(mag) << 26;

    // saturate quotient to Q5.26
    always_comb
    begin
        if (neg_reg)
            scaled = (div_q >= 50'h8000_0000) ? 32'h8000_0000 : (32'd0 - div_q[31:0]);
        else
            scaled = (div_q > 50'h7fff_ffff) ? 32'h7fff_ffff : div_q[31:0];
    end

    bpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (kind_reg ? pscale_reg : tscale_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    bpc_mulq u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Op sequence. Temperature: op0 m=c1*T, acc=c0+m.
    // Pressure: op0 c30*P +c20, op1 acc*P +c10, op2 acc*P +c00,
    // op3 c21*P +c11 -> g, op4 g*P -> g, op5 c01*T +acc, op6 g*T +acc.
    always_comb
    begin
        mul_x = acc_reg;
        mul_y = sc_reg;
        if (!kind_reg)
            mul_x = c1q;
        else
            case (op_reg)
                3'd0:    mul_x = c30q;
                3'd1,
                3'd2:    mul_x = acc_reg;
                3'd3:    mul_x = c21q;
                3'd4:    mul_x = g_reg;
                3'd5:
                begin
                    mul_x = c01q;
                    mul_y = tlast_reg;
                end
                default:
                begin
                    mul_x = g_reg;
                    mul_y = tlast_reg;
                end
            endcase
    end

    always_comb
    begin
        add_a = acc_reg;
        add_b = mres_reg;
        if (!kind_reg)
            add_a = c0q;
        else
            case (op_reg)
                3'd0:    add_a = c20q;
                3'd1:    add_a = c10q;
                3'd2:    add_a = c00q;
                3'd3:    add_a = c11q;
                3'd4:    add_a = 64'd0;
                default: add_a = acc_reg;
            endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid && in_ready)
                            state_next = allowed ? ST_DIV : ST_OUT;
            ST_DIV:     state_next = ST_SCALE;
            ST_SCALE:   if (div_done) state_next = ST_MUL_LO;
            ST_MUL_LO:  state_next = ST_MUL_FIN;
            ST_MUL_HI:  state_next = ST_MUL_FIN;
            ST_MUL_FIN: if (mul_done) state_next = ST_ADD;
            ST_ADD:     state_next = (!kind_reg || op_reg == 3'd6) ? ST_OUT : ST_MUL_LO;
            ST_OUT:     if (!ovalid_reg || out_ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next     = op_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        sc_next     = sc_reg;
        acc_next    = acc_reg;
        g_next      = g_reg;
        mres_next   = mres_reg;
        raw_next    = raw_reg;
        neg_next    = neg_reg;
        tlast_next  = tlast_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        div_start   = 1'b0;
        mul_start   = 1'b0;
        in_ready    = 1'b0;
        if (ovalid_reg && out_ready)
            ovalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next   = in_data.action;
                    status_next = !allowed;
                    raw_next    = in_data.raw_sample[RAW_BITS-1:0];
                    neg_next    = in_data.raw_sample[RAW_BITS-1];
                    op_next     = 3'd0;
                    sc_next     = 32'd0;
                    acc_next    = 64'd0;
                end
            end
            ST_DIV:     div_start = 1'b1;
            ST_SCALE:   if (div_done) sc_next = scaled;
            ST_MUL_LO:  mul_start = 1'b1;
            ST_MUL_HI:  mul_start = 1'b0;
            ST_MUL_FIN: if (mul_done) mres_next = mul_prod;
            ST_ADD:
            begin
                op_next = op_reg + 3'd1;
                if (kind_reg && (op_reg == 3'd3 || op_reg == 3'd4))
                    g_next = sat_add64(add_a, add_b);
                else
                    acc_next = sat_add64(add_a, add_b);
                if (!kind_reg)
                    tlast_next = sc_reg;
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    out_next.kind        = kind_reg;
                    out_next.status      = status_reg;
                    out_next.scaled_raw  = sc_reg;
                    out_next.compensated = acc_reg;
                    ovalid_next          = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign cfg_ready = 1'b1;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal0_reg   <= 48'd0;
            cal1_reg   <= 48'd0;
            cal2_reg   <= 48'd0;
            mode_reg   <= 3'd0;
            pscale_reg <= SCALE_RESET;
            tscale_reg <= SCALE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CALIB0:    cal0_reg   <= cfg_data;
                CFG_CALIB1:    cal1_reg   <= cfg_data;
                CFG_CALIB2:    cal2_reg   <= cfg_data;
                CFG_MODE:      mode_reg   <= cfg_data[2:0];
                CFG_PRS_SCALE: pscale_reg <= cfg_data[20:0];
                CFG_TMP_SCALE: tscale_reg <= cfg_data[20:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            tlast_reg  <= 32'sd0;
            op_reg     <= 3'd0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            tlast_reg  <= tlast_next;
            op_reg     <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        status_reg <= status_next;
        sc_reg     <= sc_next;
        acc_reg    <= acc_next;
        g_reg      <= g_next;
        mres_reg   <= mres_next;
        raw_reg    <= raw_next;
        neg_reg    <= neg_next;
        out_reg    <= out_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;

endmodule

// ----- sim/testbench.sv -----
// Testbench for barometer_pressure_compensation: directed table, then random phases.
// Checks every result against an in-bench compensation predictor or, for some directed rows, a literal expected value.
// Depends on bpc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
    import bpc_pkg::*;

    localparam logic ACT_TEMP = 1'b0;
    localparam logic ACT_PRS  = 1'b1;
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_BAD = 1'b1;
    localparam logic [2:0] MODE_OFF  = 3'd0;
    localparam logic [2:0] MODE_RSV3 = 3'd3;
    localparam logic [2:0] MODE_RSV4 = 3'd4;
    localparam longint Q64_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint Q64_MIN = 64'sh8000_0000_0000_0000;
    localparam int TAIL_CYCLES = 120;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    bpc_in_t   in_data;
    logic      out_valid;
    logic      out_ready;
    bpc_out_t  out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;

    // Local copy of the block's registers and stored temperature
    logic [47:0] cal_w0, cal_w1, cal_w2;
    logic [2:0]  cur_mode;
    logic [20:0] prs_div, tmp_div;
    int          held_temp;

    bpc_out_t expected_q[$];
    int       error_count;
    int       burst_left;
    bit       gaps_on;

    typedef struct {
        logic [2:0]         mode;
        logic [20:0]        pscale;
        logic [20:0]        tscale;
        logic               act;
        logic signed [23:0] raw;
        bit                 lit;
        bpc_out_t           lit_v;
    } dir_row_t;

    dir_row_t dir_rows[$];

    barometer_pressure_compensation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Saturating 64-bit add
    function automatic longint add_sat(longint a, longint b);
        longint s;
        s = a + b;
        if (a >= 0 && b >= 0 && s < 0)
            return Q64_MAX;
        if (a < 0 && b < 0 && s >= 0)
            return Q64_MIN;
        return s;
    endfunction

    // Q47.16 times Q5.26, truncated toward zero, saturated to Q47.16
    function automatic longint mul_q(longint x, int y);
        logic         neg;
        logic [63:0]  mx, my, lim;
        logic [127:0] p;
        neg = (x < 0) != (y < 0);
        mx  = (x < 0) ? -x : x;
        my  = (y < 0) ? -longint'(y) : longint'(y);
        p   = (128'(mx) * 128'(my)) >> 26;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        if (p > 128'(lim))
            p = 128'(lim);
        if (neg)
            return -longint'(p[63:0]);
        return longint'(p[63:0]);
    endfunction

    // Raw sample over scale factor into Q5.26
    function automatic int raw_to_q26(logic signed [23:0] raw, logic [20:0] div);
        logic [63:0] mag, q, d;
        d   = (div == 21'd0) ? 64'd1 : 64'(div);
        mag = (raw < 0) ? -longint'(raw) : longint'(raw);
        q   = (mag << 26) / d;
        if (raw < 0)
            return (q >= 64'h8000_0000) ? 32'sh8000_0000 : -int'(q);
        return (q > 64'h7fff_ffff) ? 32'sh7fff_ffff : int'(q);
    endfunction

    // Expected result of one item; updates the stored temperature
    function automatic bpc_out_t compensate(logic act, logic signed [23:0] raw);
        bpc_out_t     r;
        logic [143:0] cb;
        longint       c0, c1, c00, c10, c01, c11, c20, c21, c30, h, g;
        int           s;
        bit           allowed;
        cb = {cal_w0, cal_w1, cal_w2};
        c0  = longint'($signed(cb[143 -: 12]));
        c1  = longint'($signed(cb[131 -: 12]));
        c00 = longint'($signed(cb[119 -: 20]));
        c10 = longint'($signed(cb[99 -: 20]));
        c01 = longint'($signed(cb[79 -: 16]));
        c11 = longint'($signed(cb[63 -: 16]));
        c20 = longint'($signed(cb[47 -: 16]));
        c21 = longint'($signed(cb[31 -: 16]));
        c30 = longint'($signed(cb[15 -: 16]));
        if (act == ACT_PRS)
            allowed = cur_mode == MODE_PRS || cur_mode == MODE_CONT_PRS || cur_mode == MODE_BOTH;
        else
            allowed = cur_mode == MODE_TMP || cur_mode == MODE_CONT_TMP || cur_mode == MODE_BOTH;
        r.kind = act;
        r.status = allowed ? STAT_OK : STAT_BAD;
        r.scaled_raw = '0;
        r.compensated = '0;
        if (allowed && act == ACT_TEMP)
        begin
            s = raw_to_q26(raw, tmp_div);
            r.scaled_raw = s;
            r.compensated = add_sat(c0 * 32768, mul_q(c1 * 65536, s));
            held_temp = s;
        end
        else if (allowed)
        begin
            s = raw_to_q26(raw, prs_div);
            r.scaled_raw = s;
            h = add_sat(c20 * 65536, mul_q(c30 * 65536, s));
            h = add_sat(c10 * 65536, mul_q(h, s));
            h = add_sat(c00 * 65536, mul_q(h, s));
            g = add_sat(c11 * 65536, mul_q(c21 * 65536, s));
            g = mul_q(g, s);
            h = add_sat(h, mul_q(c01 * 65536, held_temp));
            r.compensated = add_sat(h, mul_q(g, held_temp));
        end
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        bpc_out_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
                report("unexpected item", 64'(out_data.kind), 64'd0);
            else
            begin
                w = expected_q.pop_front();
                if (out_data.kind !== w.kind)
                    report("kind", 64'(out_data.kind), 64'(w.kind));
                if (out_data.status !== w.status)
                    report("status", 64'(out_data.status), 64'(w.status));
                if (out_data.scaled_raw !== w.scaled_raw)
                    report("scaled_raw", 64'(out_data.scaled_raw), 64'(w.scaled_raw));
                if (out_data.compensated !== w.compensated)
                    report("compensated", out_data.compensated, w.compensated);
            end
        end
    end

    // Receiver stall pattern, switching among four randomly chosen styles
    always @(negedge clk)
    begin
        int unsigned cyc;
        int unsigned style;
        if (rst_n)
        begin
            cyc++;
            if (cyc % 150 == 0)
                style = $urandom_range(0, 3);
            case (style)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= ($urandom_range(0, 7) == 0);
                default: out_ready <= (cyc % 5) < 2;
            endcase
        end
    end

    task automatic cfg_write(bpc_cfg_idx_t idx, logic [47:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_CALIB0:    cal_w0 = val;
            CFG_CALIB1:    cal_w1 = val;
            CFG_CALIB2:    cal_w2 = val;
            CFG_MODE:      cur_mode = val[2:0];
            CFG_PRS_SCALE: prs_div = val[20:0];
            default:       tmp_div = val[20:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Let the block go idle before touching registers
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_item(logic act, logic signed [23:0] raw, bit lit, bpc_out_t lit_v);
        int       gap;
        bpc_out_t p;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                gap = $urandom_range(1, 12);
        end
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= '{action: act, raw_sample: raw};
        do @(posedge clk); while (!in_ready);
        burst_left--;
        p = compensate(act, raw);
        expected_q.push_back(lit ? lit_v : p);
    endtask

    function automatic logic signed [23:0] pick_raw();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return $urandom_range(0, 1) ? 24'sd0 - 24'($urandom_range(0, 255))
                                            : 24'($urandom_range(0, 255));
            2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            default: return 24'(int'($urandom_range(0, 2 * 1048576)) - 1048576);
        endcase
    endfunction

    function automatic logic [47:0] pick_scale();
        logic [20:0] real_div[8] = '{21'd524288, 21'd1572864, 21'd917504, 21'd1966080,
                                     21'd253952, 21'd516096, 21'd1040384, 21'd2088960};
        case ($urandom_range(0, 5))
            0: return 48'(21'd1);
            1: return 48'd0;
            2: return {$urandom, 16'($urandom)};
            default: return 48'(real_div[$urandom_range(0, 7)]);
        endcase
    endfunction

    function automatic logic [47:0] pick_calib();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return 48'h7ff7ff_7ffff7;
            3: return 48'h800800_800008;
            default: return {$urandom, 16'($urandom)};
        endcase
    endfunction

    // Stimulus
    initial
    begin
        bpc_out_t bad_t, bad_p, none;
        dir_row_t row;
        logic     act;
        int       sent, phase, run_len, sent_total;
        none = '0;
        bad_t = '{kind: ACT_TEMP, status: STAT_BAD, scaled_raw: '0, compensated: '0};
        bad_p = '{kind: ACT_PRS, status: STAT_BAD, scaled_raw: '0, compensated: '0};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cal_w0 = '0;
        cal_w1 = '0;
        cal_w2 = '0;
        cur_mode = MODE_OFF;
        prs_div = SCALE_RESET;
        tmp_div = SCALE_RESET;
        held_temp = 0;
        error_count = 0;
        burst_left = 0;
        gaps_on = 1'b0;
        sent_total = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table; pressure rows in pressure-only mode see a zero temperature
        dir_rows = '{
            '{MODE_OFF, SCALE_RESET, SCALE_RESET, ACT_TEMP, 24'sd0, 1, bad_t},
            '{MODE_OFF, SCALE_RESET, SCALE_RESET, ACT_PRS, 24'sh800000, 1, bad_p},
            '{MODE_RSV3, SCALE_RESET, SCALE_RESET, ACT_TEMP, 24'sh7fffff, 1, bad_t},
            '{MODE_RSV4, SCALE_RESET, SCALE_RESET, ACT_PRS, 24'sd1, 1, bad_p},
            '{MODE_PRS, SCALE_RESET, SCALE_RESET, ACT_PRS, 24'sh7fffff, 0, none},
            '{MODE_PRS, SCALE_RESET, SCALE_RESET, ACT_PRS, 24'sh800000, 0, none},
            '{MODE_PRS, SCALE_RESET, SCALE_RESET, ACT_TEMP, 24'sd5, 1, bad_t},
            '{MODE_TMP, SCALE_RESET, SCALE_RESET, ACT_TEMP, 24'sd0, 0, none},
            '{MODE_TMP, SCALE_RESET, SCALE_RESET, ACT_TEMP, 24'sh7fffff, 0, none},
            '{MODE_TMP, SCALE_RESET, SCALE_RESET, ACT_TEMP, 24'sh800000, 0, none},
            '{MODE_TMP, SCALE_RESET, SCALE_RESET, ACT_PRS, 24'sd3, 1, bad_p},
            '{MODE_CONT_PRS, 21'd253952, 21'd253952, ACT_PRS, -24'sd1, 0, none},
            '{MODE_CONT_TMP, 21'd253952, 21'd253952, ACT_TEMP, 24'sd1, 0, none},
            '{MODE_BOTH, 21'd1040384, 21'd1040384, ACT_TEMP, 24'sd4194304, 0, none},
            '{MODE_BOTH, 21'd1040384, 21'd1040384, ACT_PRS, 24'sd2000000, 0, none},
            // zero scale factor acts as one and saturates the scaled sample
            '{MODE_BOTH, 21'd0, 21'd0, ACT_TEMP, 24'sh7fffff, 0, none},
            '{MODE_BOTH, 21'd0, 21'd0, ACT_PRS, 24'sh800000, 0, none},
            '{MODE_BOTH, 21'd1, 21'd1, ACT_TEMP, -24'sd1, 0, none},
            '{MODE_BOTH, 21'd1, 21'd1, ACT_PRS, 24'sh7fffff, 0, none},
            '{MODE_BOTH, 21'd2088960, 21'd2088960, ACT_TEMP, 24'sh800000, 0, none},
            '{MODE_BOTH, 21'd2088960, 21'd2088960, ACT_PRS, 24'sh7fffff, 0, none}
        };
        cfg_write(CFG_CALIB0, 48'h1f2e4d_0a3c71);
        cfg_write(CFG_CALIB1, 48'hb59a_e46f_0c38);
        cfg_write(CFG_CALIB2, 48'hf7a2_0391_fe55);
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.mode != cur_mode || row.pscale != prs_div || row.tscale != tmp_div)
            begin
                drain();
                if (row.mode != cur_mode)
                    cfg_write(CFG_MODE, 48'(row.mode));
                if (row.pscale != prs_div)
                    cfg_write(CFG_PRS_SCALE, 48'(row.pscale));
                if (row.tscale != tmp_div)
                    cfg_write(CFG_TMP_SCALE, 48'(row.tscale));
            end
            send_item(row.act, row.raw, row.lit, row.lit_v);
        end

        // Random phases: mostly a temperature followed by a run of pressures
        phase = 0;
        while (sent_total < 1080 && phase < 40)
        begin
            drain();
            cfg_write(CFG_CALIB0, pick_calib());
            cfg_write(CFG_CALIB1, pick_calib());
            cfg_write(CFG_CALIB2, pick_calib());
            cfg_write(CFG_PRS_SCALE, pick_scale());
            cfg_write(CFG_TMP_SCALE, pick_scale());
            if ($urandom_range(0, 9) < 7)
                cfg_write(CFG_MODE, 48'(MODE_BOTH));
            else
                cfg_write(CFG_MODE, {$urandom, 16'($urandom)});
            gaps_on = $urandom_range(0, 2) != 0;
            burst_left = 0;
            sent = 0;
            while (sent < 90)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    act = $urandom_range(0, 1);
                    send_item(act, pick_raw(), 0, none);
                    sent++;
                end
                else
                begin
                    send_item(ACT_TEMP, pick_raw(), 0, none);
                    run_len = $urandom_range(1, 8);
                    repeat (run_len)
                        send_item(ACT_PRS, pick_raw(), 0, none);
                    sent += run_len + 1;
                end
            end
            sent_total += sent;
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
